// ----- hw/rtl/cle_pkg.sv -----
`default_nettype none

package cle_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_TRAVERSE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STATUS_DONE     = 3'd0,
    STATUS_ELEMENT  = 3'd1,
    STATUS_EMPTY    = 3'd2,
    STATUS_NOTFOUND = 3'd3,
    STATUS_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_LINK,
    S_INS_TAIL,
    S_DEL_WALK,
    S_DEL_LINK,
    S_TRV_WALK
  } state_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] item_value;
    logic                      last;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cle_ram.sv -----
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/circular_list_engine_unit.sv -----
// Channel   Ports                    Handshake
// command   cmd (kind, value)        taken when start is high and busy is low
// response  rsp (status, item_value, last)  valid for one cycle while rsp_strobe is high
//
// Insert completes in S_IDLE on an empty list or a full pool, otherwise it passes through
// S_INS_LINK and S_INS_TAIL. Delete and traverse set up in S_IDLE, then visit one node per cycle;
// each visit is one read of the value and link memories.
// A delete that unlinks a node from a longer list also passes through S_DEL_LINK to relink it.
// Each response appears in the cycle after the one that produced it.
// Reset clears the list to empty; the response side cannot stall the unit.
`default_nettype none

module circular_list_engine_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cle_pkg::cmd_t cmd,
  output cle_pkg::rsp_t      rsp,
  output logic               rsp_strobe
);

  import cle_pkg::*;

  state_t                    state, state_next;
  logic [SLOT_W-1:0]         head, head_next;
  logic [COUNT_W-1:0]        count, count_next;
  logic [CAPACITY-1:0]       used, used_next;
  logic [SLOT_W-1:0]         cur, cur_next;
  logic [SLOT_W-1:0]         slot, slot_next;
  logic [SLOT_W-1:0]         link_a, link_a_next;
  logic [SLOT_W-1:0]         link_b, link_b_next;
  logic [COUNT_W-1:0]        visited, visited_next;
  logic signed [VALUE_W-1:0] value, value_next;
  rsp_t                      rsp_next;
  logic                      rsp_strobe_next;

  logic [SLOT_W-1:0]         rd_addr;
  logic [VALUE_W-1:0]        val_rdata;
  logic [SLOT_W-1:0]         nxt_rdata;
  logic [SLOT_W-1:0]         prv_rdata;
  logic                      val_we, nxt_we, prv_we;
  logic [SLOT_W-1:0]         val_waddr, nxt_waddr, prv_waddr;
  logic [VALUE_W-1:0]        val_wdata;
  logic [SLOT_W-1:0]         nxt_wdata, prv_wdata;

  logic [SLOT_W-1:0]         free_slot;
  logic                      free_found;

  cle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (rd_addr),
    .rdata (nxt_rdata)
  );

  cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prv_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (rd_addr),
    .rdata (prv_rdata)
  );

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!free_found && !used[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      used       <= '0;
      rsp_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      count      <= count_next;
      used       <= used_next;
      rsp_strobe <= rsp_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    slot    <= slot_next;
    link_a  <= link_a_next;
    link_b  <= link_b_next;
    visited <= visited_next;
    value   <= value_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    used_next       = used;
    cur_next        = cur;
    slot_next       = slot;
    link_a_next     = link_a;
    link_b_next     = link_b;
    visited_next    = visited;
    value_next      = value;
    rsp_next        = rsp;
    rsp_strobe_next = 1'b0;

    rd_addr   = nxt_rdata;
    val_we    = 1'b0;
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    val_waddr = slot;
    nxt_waddr = slot;
    prv_waddr = slot;
    val_wdata = value;
    nxt_wdata = head;
    prv_wdata = link_a;

    unique case (state)
      S_IDLE: begin
        rd_addr = head;
        if (start) begin
          value_next   = cmd.value;
          cur_next     = head;
          visited_next = COUNT_W'(1);
          slot_next    = free_slot;
          rsp_next     = '{status: STATUS_DONE, item_value: '0, last: 1'b1};
          case (cmd.kind)
            KIND_INSERT: begin
              if (count == COUNT_W'(CAPACITY) || !free_found) begin
                rsp_next.status = STATUS_FULL;
                rsp_strobe_next = 1'b1;
              end else if (count == '0) begin
                val_we          = 1'b1;
                nxt_we          = 1'b1;
                prv_we          = 1'b1;
                val_waddr       = free_slot;
                nxt_waddr       = free_slot;
                prv_waddr       = free_slot;
                val_wdata       = cmd.value;
                nxt_wdata       = free_slot;
                prv_wdata       = free_slot;
                head_next       = free_slot;
                used_next[free_slot] = 1'b1;
                count_next      = count + COUNT_W'(1);
                rsp_strobe_next = 1'b1;
              end else begin
                state_next = S_INS_LINK;
              end
            end
            KIND_DELETE: begin
              if (count == '0) begin
                rsp_next.status = STATUS_EMPTY;
                rsp_strobe_next = 1'b1;
              end else begin
                state_next = S_DEL_WALK;
              end
            end
            KIND_TRAVERSE: begin
              if (count == '0) begin
                rsp_next.status = STATUS_EMPTY;
                rsp_strobe_next = 1'b1;
              end else begin
                state_next = S_TRV_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_LINK: begin
        link_a_next = prv_rdata;
        val_we      = 1'b1;
        nxt_we      = 1'b1;
        prv_we      = 1'b1;
        nxt_wdata   = head;
        prv_wdata   = prv_rdata;
        state_next  = S_INS_TAIL;
      end

      S_INS_TAIL: begin
        nxt_we          = 1'b1;
        nxt_waddr       = link_a;
        nxt_wdata       = slot;
        prv_we          = 1'b1;
        prv_waddr       = head;
        prv_wdata       = slot;
        used_next[slot] = 1'b1;
        count_next      = count + COUNT_W'(1);
        rsp_strobe_next = 1'b1;
        state_next      = S_IDLE;
      end

      S_DEL_WALK: begin
        if (val_rdata == value) begin
          link_a_next = nxt_rdata;
          link_b_next = prv_rdata;
          if (count == COUNT_W'(1)) begin
            used_next[cur]  = 1'b0;
            count_next      = '0;
            head_next       = '0;
            rsp_strobe_next = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_DEL_LINK;
          end
        end else if (visited == count) begin
          rsp_next.status = STATUS_NOTFOUND;
          rsp_strobe_next = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cur_next     = nxt_rdata;
          visited_next = visited + COUNT_W'(1);
        end
      end

      S_DEL_LINK: begin
        nxt_we         = 1'b1;
        nxt_waddr      = link_b;
        nxt_wdata      = link_a;
        prv_we         = 1'b1;
        prv_waddr      = link_a;
        prv_wdata      = link_b;
        used_next[cur] = 1'b0;
        if (cur == head) begin
          head_next = link_a;
        end
        count_next      = count - COUNT_W'(1);
        rsp_strobe_next = 1'b1;
        state_next      = S_IDLE;
      end

      S_TRV_WALK: begin
        rsp_next.status     = STATUS_ELEMENT;
        rsp_next.item_value = val_rdata;
        rsp_next.last       = (visited == count);
        rsp_strobe_next     = 1'b1;
        visited_next        = visited + COUNT_W'(1);
        if (visited == count) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- dv/circular_list_engine_checker.sv -----
`timescale 1ns / 100ps

module circular_list_engine_checker
  import cle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  cmd_t cmd,
  input  rsp_t rsp,
  input  logic rsp_strobe,
  output int   errors,
  output int   pending
);

  logic signed [VALUE_W-1:0] node_val  [CAPACITY];
  logic        [SLOT_W-1:0]  fwd_link  [CAPACITY];
  logic        [SLOT_W-1:0]  back_link [CAPACITY];
  bit                        in_use    [CAPACITY];
  logic        [SLOT_W-1:0]  head;
  int                        count;
  rsp_t                      list_rsp_q [$];

  function automatic rsp_t answer(status_t s, logic signed [VALUE_W-1:0] v, logic l);
    rsp_t r;
    r.status     = s;
    r.item_value = v;
    r.last       = l;
    return r;
  endfunction

  task automatic update_list(input cmd_t c);
    int                free_slot;
    int                i;
    bit                hit;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] nx;
    logic [SLOT_W-1:0] pv;
    logic [SLOT_W-1:0] tail;
    case (c.kind)
      KIND_INSERT: begin
        free_slot = -1;
        for (i = CAPACITY - 1; i >= 0; i--) begin
          if (!in_use[i]) free_slot = i;
        end
        if (count >= CAPACITY || free_slot < 0) begin
          list_rsp_q.push_back(answer(STATUS_FULL, '0, 1'b1));
        end else begin
          node_val[free_slot] = c.value;
          in_use[free_slot]   = 1'b1;
          if (count == 0) begin
            head                 = free_slot[SLOT_W-1:0];
            fwd_link[free_slot]  = free_slot[SLOT_W-1:0];
            back_link[free_slot] = free_slot[SLOT_W-1:0];
          end else begin
            tail                 = back_link[head];
            fwd_link[free_slot]  = head;
            back_link[free_slot] = tail;
            fwd_link[tail]       = free_slot[SLOT_W-1:0];
            back_link[head]      = free_slot[SLOT_W-1:0];
          end
          count++;
          list_rsp_q.push_back(answer(STATUS_DONE, '0, 1'b1));
        end
      end
      KIND_DELETE: begin
        if (count == 0) begin
          list_rsp_q.push_back(answer(STATUS_EMPTY, '0, 1'b1));
        end else begin
          hit = 1'b0;
          cur = head;
          for (i = 0; i < count; i++) begin
            if (!hit) begin
              if (node_val[cur] == c.value) hit = 1'b1;
              else cur = fwd_link[cur];
            end
          end
          if (!hit) begin
            list_rsp_q.push_back(answer(STATUS_NOTFOUND, '0, 1'b1));
          end else begin
            in_use[cur] = 1'b0;
            if (count == 1) begin
              count = 0;
              head  = '0;
            end else begin
              nx            = fwd_link[cur];
              pv            = back_link[cur];
              fwd_link[pv]  = nx;
              back_link[nx] = pv;
              if (cur == head) head = nx;
              count--;
            end
            list_rsp_q.push_back(answer(STATUS_DONE, '0, 1'b1));
          end
        end
      end
      KIND_TRAVERSE: begin
        if (count == 0) begin
          list_rsp_q.push_back(answer(STATUS_EMPTY, '0, 1'b1));
        end else begin
          cur = head;
          for (i = 0; i < count; i++) begin
            list_rsp_q.push_back(answer(STATUS_ELEMENT, node_val[cur], i == count - 1));
            cur = fwd_link[cur];
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) in_use[i] = 1'b0;
      head   = '0;
      count  = 0;
      list_rsp_q.delete();
      errors = 0;
    end else begin
      if (rsp_strobe) begin
        if (list_rsp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction: status=%0d value=%0d last=%0b",
                   $time, rsp.status, rsp.item_value, rsp.last);
        end else begin
          exp_rsp = list_rsp_q.pop_front();
          if (rsp.status !== exp_rsp.status || rsp.item_value !== exp_rsp.item_value ||
              rsp.last !== exp_rsp.last) begin
            errors++;
            $display("%0t: expected status=%0d value=%0d last=%0b, actual status=%0d value=%0d last=%0b",
                     $time, exp_rsp.status, exp_rsp.item_value, exp_rsp.last,
                     rsp.status, rsp.item_value, rsp.last);
          end
        end
      end
      if (start && !busy) update_list(cmd);
    end
    pending = list_rsp_q.size();
  end

endmodule

// ----- dv/circular_list_engine_unit_tb.sv -----
`timescale 1ns / 100ps

module circular_list_engine_unit_tb;
  import cle_pkg::*;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
  localparam kind_t KIND_UNUSED = kind_t'(2'd3);
  localparam int    RANDOM_ITEMS = 210;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic rsp_strobe;
  cmd_t cmd;
  rsp_t rsp;
  int   errors;
  int   pending;
  int   burst_left;
  int   recent_wr;
  logic signed [VALUE_W-1:0] recent [8];

  circular_list_engine_unit dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .rsp        (rsp),
    .rsp_strobe (rsp_strobe)
  );

  circular_list_engine_checker list_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .rsp        (rsp),
    .rsp_strobe (rsp_strobe),
    .errors     (errors),
    .pending    (pending)
  );

  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 5);
    if (roll < 48) return ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
    if (roll < 55) return ($urandom_range(0, 1) != 0) ? '0 : '1;
    if (roll < 75) return recent[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic send_cmd(input kind_t k, input logic signed [VALUE_W-1:0] v);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start     = 1'b1;
    cmd.kind  = k;
    cmd.value = v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k == KIND_INSERT) begin
      recent[recent_wr] = v;
      recent_wr = (recent_wr + 1) % 8;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int    n;
    int    roll;
    int    mode;
    int    ins_cut;
    int    del_cut;
    int    trv_cut;
    kind_t k;

    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    burst_left = 0;
    recent_wr  = 0;
    for (int i = 0; i < 8; i++) recent[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_cmd(KIND_TRAVERSE, 32'sd9);
    send_cmd(KIND_DELETE, 32'sd5);
    send_cmd(KIND_INSERT, VAL_MIN);
    send_cmd(KIND_INSERT, VAL_MAX);
    send_cmd(KIND_INSERT, '0);
    send_cmd(KIND_INSERT, '1);
    send_cmd(KIND_INSERT, '0);
    send_cmd(KIND_TRAVERSE, '1);
    send_cmd(KIND_DELETE, 32'sd7);
    send_cmd(KIND_DELETE, VAL_MIN);
    send_cmd(KIND_DELETE, '0);
    send_cmd(KIND_DELETE, '0);
    send_cmd(KIND_UNUSED, '1);
    send_cmd(KIND_TRAVERSE, '0);
    send_cmd(KIND_DELETE, VAL_MAX);
    send_cmd(KIND_DELETE, '1);
    send_cmd(KIND_TRAVERSE, VAL_MIN);
    send_cmd(KIND_INSERT, 32'sd42);
    send_cmd(KIND_DELETE, 32'sd42);

    n    = 0;
    mode = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 35 == 0 && n != 0) mode = $urandom_range(0, 2);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      case (mode)
        0: begin ins_cut = 80; del_cut = 90; trv_cut = 98; end
        1: begin ins_cut = 20; del_cut = 80; trv_cut = 97; end
        default: begin ins_cut = 45; del_cut = 75; trv_cut = 97; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_cut) k = KIND_INSERT;
      else if (roll < del_cut) k = KIND_DELETE;
      else if (roll < trv_cut) k = KIND_TRAVERSE;
      else k = KIND_UNUSED;
      send_cmd(k, ($urandom_range(0, 2) == 0) ? VALUE_W'($urandom()) : pick_value());
      if (k != KIND_UNUSED) n++;
    end

    wait_drained();
    repeat (2 * CAPACITY + 4) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
